// ===== src/mltd_pkg.sv =====
// shared types and constants for the length/type deframer with acknowledgement
package mltd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ACK_IDX_W = 3;
  localparam int TDATA_W   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE = 2'd2;

  localparam logic [BYTE_W-1:0] MAGIC_RST    = 8'hA5;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 16'd4096;
  localparam logic [BYTE_W-1:0] ACK_TYPE_RST = 8'h81;

  // acknowledgement frame: magic, length high, length low, ack type, frame type
  localparam logic [ACK_IDX_W-1:0] ACK_MAGIC   = 3'd0;
  localparam logic [ACK_IDX_W-1:0] ACK_LEN_HI  = 3'd1;
  localparam logic [ACK_IDX_W-1:0] ACK_LEN_LO  = 3'd2;
  localparam logic [ACK_IDX_W-1:0] ACK_TYPE    = 3'd3;
  localparam logic [ACK_IDX_W-1:0] ACK_PAYLOAD = 3'd4;
  localparam logic [BYTE_W-1:0] ACK_LEN_HI_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] ACK_LEN_LO_BYTE = 8'h01;

  localparam logic PORT_HOST   = 1'b0;
  localparam logic PORT_DEVICE = 1'b1;

  localparam logic [1:0] FILL_FULL = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAY,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_pay;
    logic load_ack;
  } cmd_t;

  typedef struct packed {
    logic in_payload;
    logic ack_now;
    logic ack_pending;
    logic ack_last;
    logic out_free;
  } status_t;

endpackage

// ===== src/magic_length_type_deframer_with_ack.sv =====
// top level: frame deframer with header resync and acknowledgement generation
//
// bytes enter one per item on the slave stream. outside a frame they fill a
// four-byte header window (magic, big-endian length, type); a full window with
// a wrong magic or an oversize length drops its oldest byte and waits for more.
// payload bytes leave on the master stream with tuser = 0, tagged with the type.
// when a frame completes (last payload byte, or a zero-length header) a
// five-byte acknowledgement follows with tuser = 1. tlast marks the final item
// caused by one input byte.
// steps: a header byte is only accepted; a payload byte is accepted, then loaded
// into the output register; a completed frame then adds one load per
// acknowledgement byte, all set by the single output register and sequencer.
// the next input is taken while the last result still waits in the output
// register. when the receiver stalls, the sequencer holds in its payload or acknowledgement state, where tready is low.
// reset clears the frame state, the counter and the output valid, and loads the
// register defaults. the user must write configuration only while idle; the block does not enforce this.
module magic_length_type_deframer_with_ack
  import mltd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,   // data_byte, frame_type, frame_end, frames_seen
  output logic                 m_tuser,   // port
  output logic                 m_tlast
);

  cmd_t    cmd;
  status_t status;

  mltd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mltd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== src/mltd_ctrl.sv =====
// controller: sequences the payload item and the acknowledgement bytes
module mltd_ctrl
  import mltd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.in_payload) begin
            state_next = ST_PAY;
          end else if (status.ack_now) begin
            state_next = ST_ACK;
          end
        end
      end
      ST_PAY: begin
        if (status.out_free) begin
          cmd.load_pay = 1'b1;
          state_next   = status.ack_pending ? ST_ACK : ST_IDLE;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd.load_ack = 1'b1;
          if (status.ack_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/mltd_datapath.sv =====
// datapath: config registers, header window, frame state and output register
module mltd_datapath
  import mltd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  logic [BYTE_W-1:0]    magic_value;
  logic [LEN_W-1:0]     max_length;
  logic [BYTE_W-1:0]    ack_type;

  logic [BYTE_W-1:0]    win0, win1, win2;
  logic [1:0]           fill;
  logic                 in_payload;
  logic [LEN_W-1:0]     remaining;
  logic [BYTE_W-1:0]    cur_type;
  logic [LEN_W-1:0]     frame_counter;
  logic [BYTE_W-1:0]    rx_hold;
  logic                 pay_end;
  logic                 ack_pending;
  logic [ACK_IDX_W-1:0] ack_idx;

  logic                 out_port;
  logic [BYTE_W-1:0]    out_data;
  logic [BYTE_W-1:0]    out_type;
  logic                 out_end;
  logic [LEN_W-1:0]     out_seen;

  logic [LEN_W-1:0]     hdr_len;
  logic                 hdr_good;
  logic                 pay_done;
  logic                 ack_now;
  logic [BYTE_W-1:0]    ack_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= MAGIC_RST;
      max_length  <= MAX_LEN_RST;
      ack_type    <= ACK_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:    magic_value <= cfg_data[BYTE_W-1:0];
        REG_MAX_LEN:  max_length  <= cfg_data[LEN_W-1:0];
        REG_ACK_TYPE: ack_type    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // the incoming byte completes the header when three are already held
  assign hdr_len  = {win1, win2};
  assign hdr_good = (win0 == magic_value) && (hdr_len <= max_length);
  assign pay_done = (remaining <= 16'd1);
  assign ack_now  = in_payload ? pay_done
                               : ((fill == FILL_FULL) && hdr_good && (hdr_len == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      in_payload    <= 1'b0;
      remaining     <= '0;
      cur_type      <= '0;
      frame_counter <= '0;
      ack_pending   <= 1'b0;
    end else begin
      if (cmd.accept) begin
        ack_pending <= ack_now;
        if (ack_now && (frame_counter != '1)) begin
          frame_counter <= frame_counter + 16'd1;
        end
        if (in_payload) begin
          if (remaining != '0) begin
            remaining <= remaining - 16'd1;
          end
          if (pay_done) begin
            in_payload <= 1'b0;
          end
        end else if (fill == FILL_FULL) begin
          if (hdr_good) begin
            cur_type <= rx_byte;
            fill     <= '0;
            if (hdr_len != '0) begin
              in_payload <= 1'b1;
              remaining  <= hdr_len;
            end
          end
        end else begin
          fill <= fill + 2'd1;
        end
      end else if (cmd.load_ack && (ack_idx == ACK_PAYLOAD)) begin
        ack_pending <= 1'b0;
      end
    end
  end

  // window bytes need no reset: only entries written since the frame began are read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rx_hold <= rx_byte;
      pay_end <= pay_done;
      if (!in_payload) begin
        if (fill == FILL_FULL) begin
          // full window: drop the oldest byte and slide (a good header restarts the fill)
          win0 <= win1;
          win1 <= win2;
          win2 <= rx_byte;
        end else begin
          case (fill)
            2'd0:    win0 <= rx_byte;
            2'd1:    win1 <= rx_byte;
            default: win2 <= rx_byte;
          endcase
        end
      end
    end
  end

  always_comb begin
    unique case (ack_idx)
      ACK_MAGIC:  ack_byte = magic_value;
      ACK_LEN_HI: ack_byte = ACK_LEN_HI_BYTE;
      ACK_LEN_LO: ack_byte = ACK_LEN_LO_BYTE;
      ACK_TYPE:   ack_byte = ack_type;
      default:    ack_byte = cur_type;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_idx <= '0;
    end else if (cmd.load_ack) begin
      ack_idx <= (ack_idx == ACK_PAYLOAD) ? '0 : ack_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_pay || cmd.load_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pay) begin
      out_port <= PORT_HOST;
      out_data <= rx_hold;
      out_type <= cur_type;
      out_end  <= pay_end;
      out_seen <= frame_counter;
      m_tlast  <= !ack_pending;
    end else if (cmd.load_ack) begin
      out_port <= PORT_DEVICE;
      out_data <= ack_byte;
      out_type <= ack_type;
      out_end  <= (ack_idx == ACK_PAYLOAD);
      out_seen <= frame_counter;
      m_tlast  <= (ack_idx == ACK_PAYLOAD);
    end
  end

  assign m_tdata = {7'd0, out_seen, out_end, out_type, out_data};
  assign m_tuser = out_port;

  assign status.in_payload  = in_payload;
  assign status.ack_now     = ack_now;
  assign status.ack_pending = ack_pending;
  assign status.ack_last    = (ack_idx == ACK_PAYLOAD);
  assign status.out_free    = !m_tvalid || m_tready;

endmodule

// ===== tb/magic_length_type_deframer_with_ack_tb.sv =====
// testbench for the frame deframer: byte stimulus, frame predictor and result checker
module magic_length_type_deframer_with_ack_tb;
  import mltd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] MAGIC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] MAGIC_ONES = 8'hFF;
  localparam logic [BYTE_W-1:0] MAGIC_MID  = 8'h5A;

  typedef struct {
    logic              port;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] frame_type;
    logic              frame_end;
    logic [LEN_W-1:0]  frames_seen;
    logic              is_last;
  } out_item_t;

  typedef enum int {
    READY_ALWAYS,
    READY_SOMETIMES,
    READY_RARELY
  } ready_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata = '0;     // rx_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;          // data_byte, frame_type, frame_end, frames_seen
  logic                 m_tuser;          // port
  logic                 m_tlast;

  // predictor copy of registers and frame state
  logic [BYTE_W-1:0] cfg_magic = MAGIC_RST;
  logic [LEN_W-1:0]  cfg_max_len = MAX_LEN_RST;
  logic [BYTE_W-1:0] cfg_ack = ACK_TYPE_RST;
  logic [BYTE_W-1:0] hdr [4];
  int                hdr_fill = 0;
  logic              in_frame = 1'b0;
  logic [LEN_W-1:0]  bytes_left = '0;
  logic [BYTE_W-1:0] cur_type = '0;
  logic [LEN_W-1:0]  frame_cnt = '0;

  out_item_t         expected_out[$];
  logic [BYTE_W-1:0] rx_pending[$];
  out_item_t         want;

  int          errors = 0;
  int          rx_count = 0;
  int          results_checked = 0;
  int          stim_items = 0;
  bit          fast_mode = 1'b0;
  bit          rx_item_taken = 1'b0;
  int          rx_burst = 0;
  int          rx_gap = 0;
  int          stall_left = 0;
  int          mode_cycles = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  magic_length_type_deframer_with_ack dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #4 clk = ~clk;

  task automatic predict_rx(input logic [BYTE_W-1:0] b);
    out_item_t         outs[$];
    logic [BYTE_W-1:0] ack_bytes [5];
    logic [LEN_W-1:0]  len;
    logic              done;
    done = 1'b0;
    if (in_frame) begin
      outs.push_back('{PORT_HOST, b, cur_type, bytes_left <= 1, 16'd0, 1'b0});
      if (bytes_left != 0) bytes_left--;
      if (bytes_left == 0) begin
        in_frame = 1'b0;
        done = 1'b1;
      end
    end else begin
      if (hdr_fill >= 4) hdr_fill = 3;
      hdr[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill == 4) begin
        len = {hdr[1], hdr[2]};
        if (hdr[0] == cfg_magic && len <= cfg_max_len) begin
          cur_type = hdr[3];
          hdr_fill = 0;
          if (len == 0) begin
            done = 1'b1;
          end else begin
            in_frame = 1'b1;
            bytes_left = len;
          end
        end else begin
          // drop the oldest byte and wait for the next one
          hdr[0] = hdr[1];
          hdr[1] = hdr[2];
          hdr[2] = hdr[3];
          hdr_fill = 3;
        end
      end
    end
    if (done) begin
      if (frame_cnt != 16'hFFFF) frame_cnt++;
      ack_bytes = '{cfg_magic, ACK_LEN_HI_BYTE, ACK_LEN_LO_BYTE, cfg_ack, cur_type};
      for (int k = 0; k < 5; k++) begin
        outs.push_back('{PORT_DEVICE, ack_bytes[k], cfg_ack, k == 4, 16'd0, 1'b0});
      end
    end
    foreach (outs[i]) begin
      outs[i].frames_seen = frame_cnt;
      outs[i].is_last = (i == outs.size() - 1);
      expected_out.push_back(outs[i]);
    end
  endtask

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || rx_item_taken) begin
      if (rx_gap > 0 && !fast_mode) begin
        s_tvalid <= 1'b0;
        rx_gap--;
      end else if (rx_pending.size() > 0) begin
        s_tdata <= rx_pending.pop_front();
        s_tvalid <= 1'b1;
        if (rx_burst > 0) begin
          rx_burst--;
        end else begin
          rx_burst = $urandom_range(0, 24);
          rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    rx_item_taken = 1'b0;
  end

  // receiver: the stall mode is redrawn at random whenever its mode counter runs out
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      mode_cycles = $urandom_range(16, 96);
      ready_mode = ready_mode_e'($urandom_range(0, 2));
    end else begin
      mode_cycles--;
    end
    if (fast_mode) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      case (ready_mode)
        READY_SOMETIMES: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
        READY_RARELY: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(2, 8);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      // results first: they always belong to items taken at earlier edges
      if (m_tvalid && m_tready) begin
        if (expected_out.size() == 0) begin
          $error("result with nothing expected: tuser %0d tdata %h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_out.pop_front();
          if (m_tuser !== want.port) begin
            $error("port: expected %0d, got %0d", want.port, m_tuser);
            errors++;
          end
          if (m_tdata[7:0] !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== want.frame_type) begin
            $error("frame_type: expected %h, got %h", want.frame_type, m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[16] !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, m_tdata[16]);
            errors++;
          end
          if (m_tdata[32:17] !== want.frames_seen) begin
            $error("frames_seen: expected %0d, got %0d", want.frames_seen, m_tdata[32:17]);
            errors++;
          end
          if (m_tlast !== want.is_last) begin
            $error("last: expected %0d, got %0d", want.is_last, m_tlast);
            errors++;
          end
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_rx(s_tdata);
        rx_item_taken = 1'b1;
        rx_count++;
      end
    end
  end

  function automatic bit magic_like(input logic [BYTE_W-1:0] b);
    return b inside {MAGIC_RST, MAGIC_ZERO, MAGIC_ONES, MAGIC_MID};
  endfunction

  // a byte that can never start a header under any setting used here
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom()); while (magic_like(b));
    return b;
  endfunction

  task automatic push_header(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] ftype);
    rx_pending.push_back(cfg_magic);
    rx_pending.push_back(len[15:8]);
    rx_pending.push_back(len[7:0]);
    rx_pending.push_back(ftype);
  endtask

  task automatic push_frame(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] ftype);
    push_header(len, ftype);
    for (int i = 0; i < len; i++) rx_pending.push_back(8'($urandom()));
    stim_items += 4 + len;
  endtask

  // header with an oversize length; its tail bytes are resynced past
  task automatic push_bad_header();
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] t;
    do begin
      hi = plain_byte();
      lo = plain_byte();
      t = plain_byte();
    end while ({hi, lo} <= cfg_max_len);
    rx_pending.push_back(cfg_magic);
    rx_pending.push_back(hi);
    rx_pending.push_back(lo);
    rx_pending.push_back(t);
    stim_items += 4;
  endtask

  task automatic random_mix(input int target);
    int               start;
    int               pick;
    logic [LEN_W-1:0] cap;
    start = stim_items;
    cap = (cfg_max_len < 6) ? cfg_max_len : 16'd6;
    while (stim_items - start < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        rx_pending.push_back(plain_byte());
        stim_items++;
      end else if (pick < 5 && cfg_max_len != 16'hFFFF) begin
        push_bad_header();
      end else if (pick == 5 && cfg_max_len >= 16'd40 && $urandom_range(0, 7) == 0) begin
        push_frame(16'($urandom_range(20, 40)), 8'($urandom()));
      end else begin
        push_frame(16'($urandom_range(0, cap)), 8'($urandom()));
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_pending.size() != 0 || s_tvalid || expected_out.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAGIC:    cfg_magic = val[7:0];
      REG_MAX_LEN:  cfg_max_len = val;
      REG_ACK_TYPE: cfg_ack = val[7:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset settings: empty frame, short frames with extreme bytes, resync cases
    push_header(16'd0, 8'h00);
    push_header(16'd1, 8'hFF);
    rx_pending.push_back(8'hFF);
    push_header(16'd2, 8'h7E);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h3C);
    push_header(16'd0, 8'h81);
    rx_pending.push_back(cfg_magic);
    rx_pending.push_back(8'h10);
    rx_pending.push_back(8'h01);
    rx_pending.push_back(8'h42);
    push_header(16'd0, 8'h11);
    // header left open across the register change
    rx_pending.push_back(cfg_magic);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h05);
    wait_idle();

    write_reg(REG_MAGIC, 16'(MAGIC_ZERO));
    write_reg(REG_MAX_LEN, 16'd0);
    write_reg(REG_ACK_TYPE, 16'h0000);
    write_reg(REG_UNUSED, 16'hFFFF);
    push_frame(16'd0, 8'($urandom()));
    random_mix(40);
    wait_idle();

    write_reg(REG_MAGIC, 16'(MAGIC_ONES));
    write_reg(REG_MAX_LEN, 16'hFFFF);
    write_reg(REG_ACK_TYPE, 16'h00FF);
    random_mix(40);
    wait_idle();

    write_reg(REG_MAGIC, 16'(MAGIC_MID));
    write_reg(REG_MAX_LEN, 16'd3);
    write_reg(REG_ACK_TYPE, 16'h003C);
    push_frame(16'd3, 8'h5A);
    random_mix(40);
    wait_idle();

    // back to reset values, with no sender gaps and no receiver stalls
    write_reg(REG_MAGIC, 16'(MAGIC_RST));
    write_reg(REG_MAX_LEN, MAX_LEN_RST);
    write_reg(REG_ACK_TYPE, 16'(ACK_TYPE_RST));
    fast_mode = 1'b1;
    random_mix(40);
    wait_idle();
    fast_mode = 1'b0;

    $display("checked %0d results from %0d input bytes under five register settings",
             results_checked, rx_count);
    $display("frame counter ended at %0d, the last phase ran back to back", frame_cnt);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
